[rtl/core/tccs_pkg.sv]
`timescale 1ns / 1ps
package tccs_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int TAB_STOP = 8;

	localparam int CHAR_W      = 8;
	localparam int CELL_ADDR_W = 11;
	localparam int POS_W       = 11;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int CUR_W  = $clog2(CELLS + TAB_STOP);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam int IN_FIELDS_W  = CHAR_W + CELL_ADDR_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = CHAR_W + POS_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] CODE_BACKSPACE      = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_TAB            = 8'h09;
	localparam logic [CHAR_W-1:0] CODE_LINEFEED       = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_RETURN         = 8'h0D;
	localparam logic [CHAR_W-1:0] CODE_SPACE          = 8'h20;
	localparam logic [CHAR_W-1:0] CODE_LAST_PRINTABLE = 8'h7F;

	localparam logic [0:0] MODE_PUT  = 1'b0;
	localparam logic [0:0] MODE_READ = 1'b1;

	localparam logic [ADDR_W:0] CELLS_X = (ADDR_W + 1)'(CELLS);

	typedef struct packed {
		logic [CUR_W-1:0]  pos;
		logic [CUR_W-1:0]  pos_next;
		logic              store_en;
		logic [ADDR_W-1:0] store_addr;
		logic              scroll;
		logic [ADDR_W-1:0] base;
	} cur_stat_t;

	// logical cell to RAM address, rows rotated by base
	function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] lin,
			input logic [ADDR_W-1:0] base);
		logic [ADDR_W:0] s;
		s = {1'b0, lin} + {1'b0, base};
		if (s >= CELLS_X) begin
			s = s - CELLS_X;
		end
		return s[ADDR_W-1:0];
	endfunction

endpackage

[rtl/core/text_console_cursor_scroll.sv]
`timescale 1ns / 1ps
// Text console: a put-character transfer is answered straight from the cursor logic, while a
// read-cell transfer passes through a read-wait state for the registered read of the screen RAM.
// A put that scrolls is followed by blanking the recycled row through the RAM's single write
// port; rows rotate by a base offset, so no copying is done. After reset the block fills the
// screen with spaces before it takes the first transfer. The result holds read_char (zero for
// puts) and the cursor after the transfer.
module text_console_cursor_scroll (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tccs_pkg::IN_TDATA_W-1:0]   s_tdata,  // char_code, cell_address
	input  logic                              s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tccs_pkg::OUT_TDATA_W-1:0]  m_tdata   // read_char, cursor_position
);
	import tccs_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_BLANK
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] sw_q, sw_end_q;
	logic              out_valid_q, rd_ok_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [POS_W-1:0]  out_pos_q;

	logic [CHAR_W-1:0]      char_code, rd_data, ram_wdata;
	logic [CELL_ADDR_W-1:0] cell_address;
	logic                   accept, put_en, rd_in_range, ram_we;
	logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
	cur_stat_t              cur;

	assign char_code    = s_tdata[CHAR_W-1:0];
	assign cell_address = s_tdata[IN_FIELDS_W-1:CHAR_W];

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign put_en   = accept && (s_tuser == MODE_PUT);

	assign rd_in_range = 32'(cell_address) < 32'(CELLS);

	tccs_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.put_en (put_en),
		.code   (char_code),
		.stat   (cur)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur.store_addr;
		ram_wdata = char_code;
		if (state_q == ST_CLEAR || state_q == ST_BLANK) begin
			ram_we    = 1'b1;
			ram_waddr = sw_q;
			ram_wdata = CODE_SPACE;
		end else if (put_en && cur.store_en) begin
			ram_we = 1'b1;
		end
	end

	assign ram_raddr = to_phys(ADDR_W'(cell_address), cur.base);

	tccs_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sw_q        <= '0;
			sw_end_q    <= ADDR_W'(CELLS - 1);
			out_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_char_q  <= '0;
			out_pos_q   <= '0;
		end else begin
			if (out_valid_q && m_tready && !put_en) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR, ST_BLANK: begin
					if (sw_q == sw_end_q) begin
						state_q <= ST_IDLE;
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == MODE_READ) begin
							rd_ok_q <= rd_in_range;
							state_q <= ST_READ;
						end else begin
							out_valid_q <= 1'b1;
							out_char_q  <= '0;
							out_pos_q   <= POS_W'(cur.pos_next);
							if (cur.scroll) begin
								sw_q     <= cur.base;
								sw_end_q <= cur.base + ADDR_W'(COLUMNS - 1);
								state_q  <= ST_BLANK;
							end
						end
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					out_char_q  <= rd_ok_q ? rd_data : '0;
					out_pos_q   <= POS_W'(cur.pos);
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_pos_q, out_char_q});

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !ram_we)
		else $error("screen write during read wait");

	a_read_goes_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == MODE_READ) |=> (state_q == ST_READ && !out_valid_q))
		else $error("read transfer did not enter read wait");

	a_cursor_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cur.pos < CUR_W'(CELLS))
		else $error("cursor outside screen");

	a_scroll_blanks: assert property (@(posedge clk) disable iff (!arst_n)
		(put_en && cur.scroll) |=> (state_q == ST_BLANK && ram_we))
		else $error("scroll without row blanking");

endmodule

[rtl/core/tccs_ram.sv]
`timescale 1ns / 1ps
module tccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/tccs_cursor.sv]
`timescale 1ns / 1ps
module tccs_cursor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      put_en,
	input  logic [tccs_pkg::CHAR_W-1:0] code,
	output tccs_pkg::cur_stat_t       stat
);
	import tccs_pkg::*;

	localparam logic [COL_W:0]   COLS_X   = (COL_W + 1)'(COLUMNS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [CUR_W-1:0] COLS_C   = CUR_W'(COLUMNS);
	localparam logic [CUR_W-1:0] CELLS_C  = CUR_W'(CELLS);

	logic [CUR_W-1:0]  cur_q, cur_n, cur_f;
	logic [COL_W-1:0]  col_q, col_n;
	logic [ADDR_W-1:0] base_q, base_n;
	logic [COL_W:0]    col_inc, col_sum;
	logic [3:0]        tab_adv;
	logic              printable, store_en, scroll;

	assign printable = (code >= CODE_SPACE) && (code <= CODE_LAST_PRINTABLE);
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign tab_adv   = 4'd8 - {1'b0, cur_q[2:0]};
	assign col_sum   = {1'b0, col_q} + (COL_W + 1)'(tab_adv);

	always_comb begin
		cur_n    = cur_q;
		col_n    = col_q;
		store_en = 1'b0;
		if (put_en) begin
			case (code)
				CODE_BACKSPACE: begin
					if (cur_q != '0) begin
						cur_n = cur_q - 1'b1;
						col_n = (col_q == '0) ? COL_LAST : col_q - 1'b1;
					end
				end
				CODE_TAB: begin
					cur_n = cur_q + CUR_W'(tab_adv);
					col_n = (col_sum >= COLS_X) ? COL_W'(col_sum - COLS_X) : col_sum[COL_W-1:0];
				end
				CODE_RETURN: begin
					cur_n = cur_q - CUR_W'(col_q);
					col_n = '0;
				end
				CODE_LINEFEED: begin
					cur_n = cur_q + COLS_C - CUR_W'(col_q);
					col_n = '0;
				end
				default: begin
					if (printable) begin
						store_en = 1'b1;
						cur_n    = cur_q + 1'b1;
						col_n    = (col_inc == COLS_X) ? '0 : col_inc[COL_W-1:0];
					end
				end
			endcase
		end
		scroll = put_en && (cur_n >= CELLS_C);
		cur_f  = scroll ? cur_n - COLS_C : cur_n;
		base_n = scroll ? to_phys(ADDR_W'(COLUMNS), base_q) : base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
		end else begin
			cur_q  <= cur_f;
			col_q  <= col_n;
			base_q <= base_n;
		end
	end

	assign stat.pos        = cur_q;
	assign stat.pos_next   = cur_f;
	assign stat.store_en   = store_en;
	assign stat.store_addr = to_phys(cur_q[ADDR_W-1:0], base_q);
	assign stat.scroll     = scroll;
	assign stat.base       = base_q;

endmodule

[tb/text_console_cursor_scroll_tb.sv]
`timescale 1ns / 1ps
module text_console_cursor_scroll_tb;
	import tccs_pkg::*;

	localparam int WATCHDOG_LIMIT = 10000;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 4 * COLUMNS + 40;
	localparam int RANDOM_ITEMS   = 260;

	typedef struct packed {
		logic [CHAR_W-1:0] read_char;
		logic [POS_W-1:0]  cursor_pos;
	} console_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// console state as the block should hold it
	logic [CHAR_W-1:0] screen_cells [CELLS];
	int unsigned cursor_at;

	console_result_t console_results_q [$];
	console_result_t due;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	int unsigned holds_asked = 0;
	logic tx_idle_on = 1'b1;
	logic rx_idle_on = 1'b1;

	text_console_cursor_scroll i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++) begin
			screen_cells[i] = screen_cells[i + COLUMNS];
		end
		for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
			screen_cells[i] = CODE_SPACE;
		end
		cursor_at -= COLUMNS;
	endtask

	task automatic console_step(input logic [0:0] mode, input logic [CHAR_W-1:0] code,
			input logic [CELL_ADDR_W-1:0] addr);
		console_result_t r;
		r.read_char = '0;
		if (mode == MODE_PUT) begin
			if (code == CODE_BACKSPACE) begin
				if (cursor_at > 0) begin
					cursor_at--;
				end
			end else if (code == CODE_TAB) begin
				cursor_at = (cursor_at + TAB_STOP) & ~(TAB_STOP - 1);
			end else if (code == CODE_RETURN) begin
				cursor_at -= cursor_at % COLUMNS;
			end else if (code == CODE_LINEFEED) begin
				cursor_at += COLUMNS - (cursor_at % COLUMNS);
			end else if (code >= CODE_SPACE && code <= CODE_LAST_PRINTABLE) begin
				if (cursor_at < CELLS) begin
					screen_cells[cursor_at] = code;
				end
				cursor_at++;
			end
			if (cursor_at >= CELLS) begin
				scroll_screen();
			end
		end else if (addr < CELLS) begin
			r.read_char = screen_cells[addr];
		end
		r.cursor_pos = cursor_at[POS_W-1:0];
		console_results_q.push_back(r);
	endtask

	task automatic send_item(input logic [0:0] mode, input logic [CHAR_W-1:0] code,
			input logic [CELL_ADDR_W-1:0] addr);
		while (tx_idle_on && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= IN_TDATA_W'({addr, code});
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		console_step(mode, code, addr);
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] code);
		send_item(MODE_PUT, code, CELL_ADDR_W'($urandom_range(2047)));
	endtask

	task automatic read_cell(input int unsigned addr);
		send_item(MODE_READ, CHAR_W'($urandom), CELL_ADDR_W'(addr));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (console_results_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic random_item();
		int unsigned pick;
		int unsigned dist_back;
		pick = $urandom_range(99);
		if (pick < 18) begin
			dist_back = $urandom_range(1, 200);
			pick = $urandom_range(9);
			if (pick < 6 && cursor_at >= dist_back) begin
				read_cell(cursor_at - dist_back);
			end else if (pick < 8) begin
				read_cell($urandom_range(CELLS - 1));
			end else begin
				read_cell($urandom_range(CELLS, 2047));
			end
		end else if (pick < 58) begin
			put_char(CHAR_W'($urandom_range(CODE_SPACE, CODE_LAST_PRINTABLE)));
		end else if (pick < 70) begin
			put_char(CODE_LINEFEED);
		end else if (pick < 75) begin
			put_char(CODE_TAB);
		end else if (pick < 80) begin
			put_char(CODE_RETURN);
		end else if (pick < 85) begin
			put_char(CODE_BACKSPACE);
		end else if (pick < 92) begin
			put_char(CHAR_W'($urandom_range(31)));
		end else begin
			put_char(CHAR_W'($urandom_range(128, 255)));
		end
	endtask

	task automatic test_put_codes();
		read_cell(0);
		read_cell(CELLS - 1);
		read_cell(CELLS);
		read_cell(2047);
		put_char(CODE_BACKSPACE);
		put_char(CODE_SPACE);
		put_char(CODE_LAST_PRINTABLE);
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'h1F);
		put_char(8'h80);
		put_char(8'hFF);
		put_char(8'hAA);
		put_char(CODE_TAB);
		put_char(8'h55);
		put_char(CODE_BACKSPACE);
		put_char(CODE_RETURN);
		put_char(CODE_BACKSPACE);
		put_char(CODE_LINEFEED);
		put_char(8'h5A);
		read_cell(0);
		read_cell(1);
		read_cell(2);
		read_cell(COLUMNS);
	endtask

	task automatic test_scroll();
		put_char(CODE_RETURN);
		repeat (ROWS - 1) put_char(CODE_LINEFEED);
		repeat (COLUMNS / TAB_STOP - 1) put_char(CODE_TAB);
		for (int i = 0; i < TAB_STOP; i++) begin
			put_char(CHAR_W'(8'h30 + i));
		end
		read_cell(CELLS - COLUMNS - 1);
		read_cell(CELLS - 1);
		put_char(8'h7E);
		repeat (COLUMNS / TAB_STOP) put_char(CODE_TAB);
		read_cell(CELLS - COLUMNS * 2);
		read_cell(CELLS - COLUMNS);
		put_char(CODE_LINEFEED);
		read_cell(CELLS - COLUMNS * 3);
	endtask

	task automatic test_random();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tx_idle_on = !(n >= 100 && n < 200);
			rx_idle_on = tx_idle_on;
			random_item();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_output_holdoff();
		holds_asked++;
		repeat (60) random_item();
	endtask

	task automatic test_sender_pause();
		repeat (30) random_item();
		wait_results_drained();
		repeat (20) read_cell($urandom_range(CELLS - 1));
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			screen_cells[i] = CODE_SPACE;
		end
		cursor_at = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_put_codes();
		test_scroll();
		test_output_holdoff();
		test_sender_pause();
		test_random();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (console_results_q.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", console_results_q.size()));
		end
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// result side: random stalls plus a long hold-off on request
	initial begin
		int held_n;
		int unsigned holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				for (held_n = 0; held_n < HOLD_CYCLES; held_n++) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
			end
			m_tready <= !(rx_idle_on && $urandom_range(99) < 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (console_results_q.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer, tdata %h", m_tdata));
			end else begin
				due = console_results_q.pop_front();
				if (m_tdata[CHAR_W-1:0] !== due.read_char) begin
					report_mismatch($sformatf("read_char got %h want %h",
						m_tdata[CHAR_W-1:0], due.read_char));
				end
				if (m_tdata[CHAR_W +: POS_W] !== due.cursor_pos) begin
					report_mismatch($sformatf("cursor_position got %0d want %0d",
						m_tdata[CHAR_W +: POS_W], due.cursor_pos));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule

[sim.f]
rtl/core/tccs_pkg.sv
rtl/core/tccs_ram.sv
rtl/core/tccs_cursor.sv
rtl/core/text_console_cursor_scroll.sv
tb/text_console_cursor_scroll_tb.sv
